// ===== hdl/assert_macros.svh =====
// Assertion helpers. Define ASSERT_OFF to drop them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)

`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== hdl/wss_pkg.sv =====
`default_nettype none

package wss_pkg;

    localparam int LEAVES      = 1024;
    localparam int LEAF_BITS   = 10;
    localparam int NODE_BITS   = LEAF_BITS + 1;
    localparam int NODE_DEPTH  = 2 * LEAVES;
    localparam int WEIGHT_BITS = 32;
    localparam int SUM_BITS    = 48;
    localparam int AMOUNT_BITS = 48;
    localparam int CFG_BITS    = 11;

    localparam logic [CFG_BITS-1:0] ITEMS_RESET = 11'd1024;

    typedef enum logic [1:0] {
        FUNC_UPDATE = 2'd0,
        FUNC_SEARCH = 2'd1,
        FUNC_READ   = 2'd2,
        FUNC_CLEAR  = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_BAD_WEIGHT = 2'd1,
        ST_RANGE      = 2'd2,
        ST_NOT_BELOW  = 2'd3
    } t_status;

    typedef struct packed {
        t_func                          func;
        logic [LEAF_BITS-1:0]           item_index;
        logic signed [AMOUNT_BITS-1:0]  amount;
    } t_in;

    typedef struct packed {
        t_status                status;
        logic [LEAF_BITS-1:0]   found_index;
        logic [WEIGHT_BITS-1:0] leaf_value;
        logic [SUM_BITS-1:0]    total_weight;
    } t_out;

endpackage

`default_nettype wire

// ===== hdl/wss_ram.sv =====
`default_nettype none

module wss_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 2048
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== hdl/weighted_sample_sum_tree_top.sv =====
// Weighted sample sum tree: 1024 leaf weights in a binary sum tree held in one RAM.
// Input channel (i_in_valid / o_in_stall, i_in_data) takes one operation per transfer:
// update leaf, search by amount, read leaf or clear all. Output channel
// (o_out_valid / i_out_stall, o_out_data) returns one result per operation.
// The user writes items_in_use through i_cfg_we / i_cfg_wdata only while idle; the block does not check this.
// One operation at a time; each level of the tree costs one RAM access:
//   update: leaf read, then read-add-write of the 10 ancestors
//   search: one left-child read per level, then the leaf read
//   read: leaf read; range and search-amount rejects: answered at once; bad weight: after the leaf read
//   clear: one RAM entry zeroed per cycle, all 2048 entries
// The root sum lives in a register as well, so totals need no RAM read.
// After reset the RAM is swept to zero, all 2048 entries, with o_in_stall high.
// A result waits in the output register while i_out_stall is high; the next input
// is taken meanwhile and its result waits internally until the register frees.
`default_nettype none

`include "assert_macros.svh"

module weighted_sample_sum_tree_top (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire wss_pkg::t_in                      i_in_data,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output wss_pkg::t_out                          o_out_data,
    input  wire logic                              i_cfg_we,
    input  wire logic [wss_pkg::CFG_BITS-1:0]      i_cfg_wdata
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_UPD_LEAF,
        S_UPD_ANC,
        S_SRCH,
        S_SRCH_LEAF,
        S_READ,
        S_DONE
    } t_state;

    t_state r_state, n_state;

    logic [wss_pkg::NODE_BITS-1:0]   r_node, n_node;
    logic [wss_pkg::AMOUNT_BITS-1:0] r_amt, n_amt;
    logic [wss_pkg::LEAF_BITS-1:0]   r_idx, n_idx;
    logic [wss_pkg::SUM_BITS-1:0]    r_delta, n_delta;
    logic [wss_pkg::SUM_BITS-1:0]    r_total, n_total;
    logic [wss_pkg::NODE_BITS-1:0]   r_clr_addr, n_clr_addr;
    logic                            r_clr_report, n_clr_report;
    logic [wss_pkg::CFG_BITS-1:0]    r_items, n_items;
    wss_pkg::t_out                   r_res, n_res;
    wss_pkg::t_out                   r_out, n_out;
    logic                            r_out_valid, n_out_valid;

    logic                            ram_we;
    logic [wss_pkg::NODE_BITS-1:0]   ram_waddr;
    logic [wss_pkg::SUM_BITS-1:0]    ram_wdata;
    logic [wss_pkg::NODE_BITS-1:0]   ram_raddr;
    logic [wss_pkg::SUM_BITS-1:0]    ram_rdata;

    logic [wss_pkg::SUM_BITS:0]      diff;
    logic                            go_left;
    logic [wss_pkg::NODE_BITS-1:0]   next_node;
    logic                            in_accept;
    logic                            idx_in_range;
    logic                            found_in_range;
    logic                            amt_bad;

    wss_ram #(
        .WIDTH (wss_pkg::SUM_BITS),
        .DEPTH (wss_pkg::NODE_DEPTH)
    ) u_nodes (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // search step: borrow of amount minus left sum selects the left child
    assign diff      = {1'b0, r_amt} - {1'b0, ram_rdata};
    assign go_left   = diff[wss_pkg::SUM_BITS];
    assign next_node = {r_node[wss_pkg::LEAF_BITS-1:0], ~go_left};

    assign idx_in_range   = ({1'b0, i_in_data.item_index} < r_items);
    assign found_in_range = ({1'b0, r_node[wss_pkg::LEAF_BITS-1:0]} < r_items);
    assign amt_bad        = |r_amt[wss_pkg::AMOUNT_BITS-1:wss_pkg::WEIGHT_BITS];

    always_comb begin
        n_state      = r_state;
        n_node       = r_node;
        n_amt        = r_amt;
        n_idx        = r_idx;
        n_delta      = r_delta;
        n_total      = r_total;
        n_clr_addr   = r_clr_addr;
        n_clr_report = r_clr_report;
        n_res        = r_res;
        n_out        = r_out;
        n_out_valid  = r_out_valid && i_out_stall;
        n_items      = i_cfg_we ? i_cfg_wdata : r_items;

        ram_we    = 1'b0;
        ram_waddr = r_node;
        ram_wdata = r_amt;
        ram_raddr = r_node;

        unique case (r_state)
            S_CLEAR: begin
                ram_we     = 1'b1;
                ram_waddr  = r_clr_addr;
                ram_wdata  = '0;
                n_clr_addr = r_clr_addr + 1'b1;
                if (&r_clr_addr) begin
                    if (r_clr_report) begin
                        n_res.status       = wss_pkg::ST_OK;
                        n_res.found_index  = r_idx;
                        n_res.leaf_value   = '0;
                        n_res.total_weight = '0;
                        n_state            = S_DONE;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_IDLE: begin
                if (in_accept) begin
                    n_idx              = i_in_data.item_index;
                    n_amt              = $unsigned(i_in_data.amount);
                    n_node             = {1'b1, i_in_data.item_index};
                    ram_raddr          = {1'b1, i_in_data.item_index};
                    n_res.status       = wss_pkg::ST_OK;
                    n_res.found_index  = i_in_data.item_index;
                    n_res.leaf_value   = '0;
                    n_res.total_weight = r_total;
                    unique case (i_in_data.func)
                        wss_pkg::FUNC_UPDATE: begin
                            if (idx_in_range) begin
                                n_state = S_UPD_LEAF;
                            end else begin
                                n_res.status = wss_pkg::ST_RANGE;
                                n_state      = S_DONE;
                            end
                        end
                        wss_pkg::FUNC_SEARCH: begin
                            if (i_in_data.amount[wss_pkg::AMOUNT_BITS-1] ||
                                ($unsigned(i_in_data.amount) >= r_total)) begin
                                n_res.status      = wss_pkg::ST_NOT_BELOW;
                                n_res.found_index = '0;
                                n_state           = S_DONE;
                            end else begin
                                n_node    = wss_pkg::NODE_BITS'(1);
                                ram_raddr = wss_pkg::NODE_BITS'(2);
                                n_state   = S_SRCH;
                            end
                        end
                        wss_pkg::FUNC_READ: begin
                            if (idx_in_range) begin
                                n_state = S_READ;
                            end else begin
                                n_res.status = wss_pkg::ST_RANGE;
                                n_state      = S_DONE;
                            end
                        end
                        wss_pkg::FUNC_CLEAR: begin
                            n_total      = '0;
                            n_clr_addr   = '0;
                            n_clr_report = 1'b1;
                            n_state      = S_CLEAR;
                        end
                    endcase
                end
            end
            S_UPD_LEAF: begin
                if (amt_bad) begin
                    n_res.status     = wss_pkg::ST_BAD_WEIGHT;
                    n_res.leaf_value = ram_rdata[wss_pkg::WEIGHT_BITS-1:0];
                    n_state          = S_DONE;
                end else begin
                    ram_we    = 1'b1;
                    ram_waddr = r_node;
                    ram_wdata = r_amt;
                    n_delta   = r_amt - ram_rdata;
                    n_total   = r_total + (r_amt - ram_rdata);
                    ram_raddr = {1'b0, r_node[wss_pkg::NODE_BITS-1:1]};
                    n_node    = {1'b0, r_node[wss_pkg::NODE_BITS-1:1]};
                    n_state   = S_UPD_ANC;
                end
            end
            S_UPD_ANC: begin
                ram_we    = 1'b1;
                ram_waddr = r_node;
                ram_wdata = ram_rdata + r_delta;
                ram_raddr = {1'b0, r_node[wss_pkg::NODE_BITS-1:1]};
                n_node    = {1'b0, r_node[wss_pkg::NODE_BITS-1:1]};
                if (r_node == wss_pkg::NODE_BITS'(1)) begin
                    n_res.status       = wss_pkg::ST_OK;
                    n_res.leaf_value   = r_amt[wss_pkg::WEIGHT_BITS-1:0];
                    n_res.total_weight = r_total;
                    n_state            = S_DONE;
                end
            end
            S_SRCH: begin
                if (!go_left) begin
                    n_amt = diff[wss_pkg::SUM_BITS-1:0];
                end
                n_node = next_node;
                if (next_node[wss_pkg::NODE_BITS-1]) begin
                    ram_raddr = next_node;
                    n_state   = S_SRCH_LEAF;
                end else begin
                    ram_raddr = {next_node[wss_pkg::LEAF_BITS-1:0], 1'b0};
                end
            end
            S_SRCH_LEAF: begin
                n_res.status      = found_in_range ? wss_pkg::ST_OK : wss_pkg::ST_RANGE;
                n_res.found_index = r_node[wss_pkg::LEAF_BITS-1:0];
                n_res.leaf_value  = ram_rdata[wss_pkg::WEIGHT_BITS-1:0];
                n_state           = S_DONE;
            end
            S_READ: begin
                n_res.leaf_value = ram_rdata[wss_pkg::WEIGHT_BITS-1:0];
                n_state          = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr_addr   <= '0;
            r_clr_report <= 1'b0;
            r_total      <= '0;
            r_items      <= wss_pkg::ITEMS_RESET;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_clr_addr   <= n_clr_addr;
            r_clr_report <= n_clr_report;
            r_total      <= n_total;
            r_items      <= n_items;
            r_out_valid  <= n_out_valid;
        end
        r_node  <= n_node;
        r_amt   <= n_amt;
        r_idx   <= n_idx;
        r_delta <= n_delta;
        r_res   <= n_res;
        r_out   <= n_out;
    end

    // a transfer always starts work, so the block leaves idle next cycle
    `ASSERT_NEXT(a_accept_leaves_idle, i_clk, i_rst_n, in_accept, r_state != S_IDLE)
    // the search walk stays above the leaf row until its last read
    `ASSERT_IMPLIES(a_search_interior, i_clk, i_rst_n, r_state == S_SRCH, !r_node[wss_pkg::NODE_BITS-1])
    // ancestor walk never reaches the unused node zero
    `ASSERT_IMPLIES(a_anc_nonzero, i_clk, i_rst_n, r_state == S_UPD_ANC, r_node != '0)
    // no RAM write outside clear sweep and update
    `ASSERT_IMPLIES(a_write_states, i_clk, i_rst_n, ram_we, (r_state == S_CLEAR) || (r_state == S_UPD_LEAF) || (r_state == S_UPD_ANC))

endmodule

`default_nettype wire
